/* sv/fmbq_pkg.sv */
// Package holding the shared types and constants of the front-middle-back queue.
package fmbq_pkg;

    localparam int FUNC_W = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int IN_W   = ((VAL_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_MIDDLE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_MIDDLE  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_POP_BACK    = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_PUSH,
        KIND_POP
    } kind_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_RD_DN,
        CMD_WR_DN,
        CMD_INS,
        CMD_RD_POS,
        CMD_CAP,
        CMD_RD_UP,
        CMD_WR_UP,
        CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  at_pos;
        logic  more;
        logic  out_busy;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_DN,
        S_WR_DN,
        S_INS,
        S_RD_POS,
        S_CAP,
        S_RD_UP,
        S_WR_UP,
        S_DONE
    } state_t;

endpackage

/* sv/front_middle_back_queue_top.sv */
// Top level of the front-middle-back queue: controller, datapath and checks.
// The queue holds up to DEPTH signed 32-bit words in a single-port-style memory and takes one
// operation word at a time. Entries behind the insertion or removal point are moved one at a
// time, each move taking a memory read and a write. A refused push, a pop on an empty queue
// and an unknown operation move no entries. The result word waits in an output register,
// and the next word is accepted while it waits.
module front_middle_back_queue_top #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int OUT_W = ((fmbq_pkg::VAL_W + CW + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0: push_value[31:0], zero fill.
    input  logic [fmbq_pkg::IN_W-1:0]    s_tdata,
    // Fields from bit 0: func[2:0].
    input  logic [fmbq_pkg::FUNC_W-1:0]  s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // Fields from bit 0: pop_value[31:0], fill_count[CW-1:0], zero fill.
    output logic [OUT_W-1:0]             m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [fmbq_pkg::STAT_W-1:0]  m_tuser
);

    fmbq_pkg::dp_cmd_t  cmd;
    fmbq_pkg::dp_stat_t stat;

    fmbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmbq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef SYNTH
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[fmbq_pkg::VAL_W +: CW] <= CW'(DEPTH)))
        else $error("fill count above depth");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == fmbq_pkg::ST_DONE || m_tuser == fmbq_pkg::ST_EMPTY
                      || m_tuser == fmbq_pkg::ST_FULL))
        else $error("illegal status code");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == fmbq_pkg::ST_EMPTY) |->
            (m_tdata[fmbq_pkg::VAL_W-1:0] == '1 && m_tdata[fmbq_pkg::VAL_W +: CW] == '0))
        else $error("empty pop result inconsistent");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == fmbq_pkg::ST_FULL) |->
            (m_tdata[fmbq_pkg::VAL_W +: CW] == CW'(DEPTH)))
        else $error("refused push while not full");
`endif

endmodule

/* sv/fmbq_datapath.sv */
// Datapath of the front-middle-back queue: entry memory, counters and output register.
module fmbq_datapath #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int AW = $clog2(DEPTH),
    localparam int OUT_W = ((fmbq_pkg::VAL_W + CW + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [fmbq_pkg::FUNC_W-1:0]  s_tuser,
    input  logic [fmbq_pkg::IN_W-1:0]    s_tdata,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [OUT_W-1:0]             m_tdata,
    output logic [fmbq_pkg::STAT_W-1:0]  m_tuser,
    input  fmbq_pkg::dp_cmd_t            cmd,
    output fmbq_pkg::dp_stat_t           stat
);

    logic [fmbq_pkg::VAL_W-1:0] mem [DEPTH];

    logic [CW-1:0]                count_reg, count_next;
    fmbq_pkg::kind_t              kind_reg, kind_next;
    logic                         out_valid_reg, out_valid_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [fmbq_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [fmbq_pkg::VAL_W-1:0]   pop_reg, pop_next;
    logic [fmbq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [fmbq_pkg::VAL_W-1:0]   rdata_reg;
    logic [fmbq_pkg::VAL_W-1:0]   out_value_reg, out_value_next;
    logic [fmbq_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [CW-1:0]                out_fill_reg, out_fill_next;

    fmbq_pkg::kind_t              load_kind;
    logic [fmbq_pkg::STAT_W-1:0]  load_status;
    logic [fmbq_pkg::VAL_W-1:0]   load_pop;
    logic [CW-1:0]                load_idx;
    logic [AW-1:0]                load_pos;
    logic [CW-1:0]                cnt_m1;

    logic                         mem_we;
    logic [AW-1:0]                mem_wa;
    logic [fmbq_pkg::VAL_W-1:0]   mem_wd;
    logic                         mem_re;
    logic [AW-1:0]                mem_ra;

    assign cnt_m1 = count_reg - CW'(1);

    always_comb
    begin
        load_kind   = fmbq_pkg::KIND_SKIP;
        load_status = fmbq_pkg::ST_DONE;
        load_pop    = '0;
        load_idx    = count_reg;
        load_pos    = '0;
        case (s_tuser) inside
            fmbq_pkg::FN_PUSH_FRONT, fmbq_pkg::FN_PUSH_MIDDLE, fmbq_pkg::FN_PUSH_BACK:
            begin
                if (count_reg >= CW'(DEPTH))
                begin
                    load_status = fmbq_pkg::ST_FULL;
                end
                else
                begin
                    load_kind = fmbq_pkg::KIND_PUSH;
                    if (s_tuser == fmbq_pkg::FN_PUSH_MIDDLE)
                    begin
                        load_pos = AW'(count_reg >> 1);
                    end
                    else if (s_tuser == fmbq_pkg::FN_PUSH_BACK)
                    begin
                        load_pos = AW'(count_reg);
                    end
                end
            end
            fmbq_pkg::FN_POP_FRONT, fmbq_pkg::FN_POP_MIDDLE, fmbq_pkg::FN_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    load_status = fmbq_pkg::ST_EMPTY;
                    load_pop    = '1;
                end
                else
                begin
                    load_kind = fmbq_pkg::KIND_POP;
                    if (s_tuser == fmbq_pkg::FN_POP_MIDDLE)
                    begin
                        load_pos = AW'(cnt_m1 >> 1);
                    end
                    else if (s_tuser == fmbq_pkg::FN_POP_BACK)
                    begin
                        load_pos = AW'(cnt_m1);
                    end
                    load_idx = CW'(load_pos);
                end
            end
            default:
            begin
                load_kind = fmbq_pkg::KIND_SKIP;
            end
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = AW'(idx_reg);
        mem_wd = rdata_reg;
        mem_re = 1'b0;
        mem_ra = pos_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        pop_next        = pop_reg;
        status_next     = status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        unique case (cmd)
            fmbq_pkg::CMD_NOP:
            begin
            end
            fmbq_pkg::CMD_LOAD:
            begin
                kind_next   = load_kind;
                status_next = load_status;
                pop_next    = load_pop;
                idx_next    = load_idx;
                pos_next    = load_pos;
                val_next    = s_tdata[fmbq_pkg::VAL_W-1:0];
            end
            fmbq_pkg::CMD_RD_DN:
            begin
                mem_re = 1'b1;
                mem_ra = AW'(idx_reg - CW'(1));
            end
            fmbq_pkg::CMD_WR_DN:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg - CW'(1);
            end
            fmbq_pkg::CMD_INS:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                mem_wd = val_reg;
            end
            fmbq_pkg::CMD_RD_POS:
            begin
                mem_re = 1'b1;
            end
            fmbq_pkg::CMD_CAP:
            begin
                pop_next = rdata_reg;
            end
            fmbq_pkg::CMD_RD_UP:
            begin
                mem_re = 1'b1;
                mem_ra = AW'(idx_reg + CW'(1));
            end
            fmbq_pkg::CMD_WR_UP:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
            end
            fmbq_pkg::CMD_EMIT:
            begin
                if (kind_reg == fmbq_pkg::KIND_PUSH)
                begin
                    count_next = count_reg + CW'(1);
                end
                else if (kind_reg == fmbq_pkg::KIND_POP)
                begin
                    count_next = count_reg - CW'(1);
                end
                out_value_next  = pop_reg;
                out_status_next = status_reg;
                out_fill_next   = count_next;
                out_valid_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            kind_reg      <= fmbq_pkg::KIND_SKIP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        pop_reg        <= pop_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    assign stat.kind     = kind_reg;
    assign stat.at_pos   = (idx_reg == CW'(pos_reg));
    assign stat.more     = (({1'b0, idx_reg} + (CW + 1)'(1)) < {1'b0, count_reg});
    assign stat.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_fill_reg, out_value_reg});
    assign m_tuser  = out_status_reg;

endmodule

/* sv/fmbq_ctrl.sv */
// Controller state machine that sequences each queue operation over the datapath.
module fmbq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fmbq_pkg::dp_stat_t  stat,
    output fmbq_pkg::dp_cmd_t   cmd
);

    fmbq_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmbq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = fmbq_pkg::S_DISPATCH;
                end
            end
            fmbq_pkg::S_DISPATCH:
            begin
                if (stat.kind == fmbq_pkg::KIND_PUSH)
                begin
                    state_next = fmbq_pkg::S_RD_DN;
                end
                else if (stat.kind == fmbq_pkg::KIND_POP)
                begin
                    state_next = fmbq_pkg::S_RD_POS;
                end
                else
                begin
                    state_next = fmbq_pkg::S_DONE;
                end
            end
            fmbq_pkg::S_RD_DN:
            begin
                state_next = stat.at_pos ? fmbq_pkg::S_INS : fmbq_pkg::S_WR_DN;
            end
            fmbq_pkg::S_WR_DN:
            begin
                state_next = fmbq_pkg::S_RD_DN;
            end
            fmbq_pkg::S_INS:
            begin
                state_next = fmbq_pkg::S_DONE;
            end
            fmbq_pkg::S_RD_POS:
            begin
                state_next = fmbq_pkg::S_CAP;
            end
            fmbq_pkg::S_CAP:
            begin
                state_next = fmbq_pkg::S_RD_UP;
            end
            fmbq_pkg::S_RD_UP:
            begin
                state_next = stat.more ? fmbq_pkg::S_WR_UP : fmbq_pkg::S_DONE;
            end
            fmbq_pkg::S_WR_UP:
            begin
                state_next = fmbq_pkg::S_RD_UP;
            end
            fmbq_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = fmbq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fmbq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = fmbq_pkg::CMD_NOP;
        unique case (state_reg)
            fmbq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd = fmbq_pkg::CMD_LOAD;
                end
            end
            fmbq_pkg::S_DISPATCH:
            begin
                cmd = fmbq_pkg::CMD_NOP;
            end
            fmbq_pkg::S_RD_DN:
            begin
                if (!stat.at_pos)
                begin
                    cmd = fmbq_pkg::CMD_RD_DN;
                end
            end
            fmbq_pkg::S_WR_DN:
            begin
                cmd = fmbq_pkg::CMD_WR_DN;
            end
            fmbq_pkg::S_INS:
            begin
                cmd = fmbq_pkg::CMD_INS;
            end
            fmbq_pkg::S_RD_POS:
            begin
                cmd = fmbq_pkg::CMD_RD_POS;
            end
            fmbq_pkg::S_CAP:
            begin
                cmd = fmbq_pkg::CMD_CAP;
            end
            fmbq_pkg::S_RD_UP:
            begin
                if (stat.more)
                begin
                    cmd = fmbq_pkg::CMD_RD_UP;
                end
            end
            fmbq_pkg::S_WR_UP:
            begin
                cmd = fmbq_pkg::CMD_WR_UP;
            end
            fmbq_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd = fmbq_pkg::CMD_EMIT;
                end
            end
            default:
            begin
                cmd = fmbq_pkg::CMD_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmbq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* tb/front_middle_back_queue_top_tb.sv */
// Self-checking testbench for the front-middle-back queue: directed table, random walks, stalls.
`timescale 1ns / 100ps

module front_middle_back_queue_top_tb;

    import fmbq_pkg::*;

    localparam int DEPTH = 64;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OUT_W = ((VAL_W + CW + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 1750;
    localparam int QUIET_TAIL_WORDS = 200;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
    localparam int HOLD_AFTER_RESULTS = 400;
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_DIR_ROWS = 21;

    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [VAL_W-1:0]  pop_value;
        logic [STAT_W-1:0] status;
        logic [CW-1:0]     fill_count;
    } queue_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
        logic              typed;
        queue_result_t     result;
    } dir_row_t;

    // Rows marked typed carry their own expected result; the rest use the predictor.
    localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
        '{FN_POP_FRONT,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_EMPTY, 7'd0}},
        '{FN_POP_MIDDLE,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_EMPTY, 7'd0}},
        '{FN_POP_BACK,    32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, ST_EMPTY, 7'd0}},
        '{FN_UNUSED_6,    32'h1234_5678, 1'b1, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_UNUSED_7,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_PUSH_FRONT,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_DONE,  7'd1}},
        '{FN_PUSH_BACK,   32'h8000_0000, 1'b1, '{32'h0000_0000, ST_DONE,  7'd2}},
        '{FN_PUSH_MIDDLE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_DONE,  7'd3}},
        '{FN_PUSH_MIDDLE, 32'h0000_0000, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_PUSH_FRONT,  32'h5555_5555, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_PUSH_BACK,   32'hAAAA_AAAA, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_MIDDLE,  32'h0000_0000, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_FRONT,   32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_UNUSED_6,    32'hDEAD_BEEF, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_BACK,    32'h0000_0000, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_MIDDLE,  32'h0000_0000, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_FRONT,   32'h0000_0000, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_BACK,    32'h0000_0000, 1'b0, '{32'h0000_0000, ST_DONE,  7'd0}},
        '{FN_POP_MIDDLE,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_EMPTY, 7'd0}},
        '{FN_PUSH_MIDDLE, 32'h0000_0001, 1'b1, '{32'h0000_0000, ST_DONE,  7'd1}},
        '{FN_POP_MIDDLE,  32'h0000_0000, 1'b1, '{32'h0000_0001, ST_DONE,  7'd0}}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [STAT_W-1:0] m_tuser;

    logic [VAL_W-1:0] shadow_entries[$];
    queue_result_t    pending_results[$];
    int               mismatches = 0;
    int               results_seen = 0;
    bit               quiet_tail = 1'b0;

    front_middle_back_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic queue_result_t apply_queue_op(input logic [FUNC_W-1:0] fn,
                                                     input logic [VAL_W-1:0] v);
        queue_result_t r;
        int            idx;
        r.pop_value = '0;
        r.status = ST_DONE;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_MIDDLE, FN_PUSH_BACK:
            begin
                if (shadow_entries.size() >= DEPTH)
                    r.status = ST_FULL;
                else if (fn == FN_PUSH_FRONT)
                    shadow_entries.push_front(v);
                else if (fn == FN_PUSH_MIDDLE)
                    shadow_entries.insert(shadow_entries.size() / 2, v);
                else
                    shadow_entries.push_back(v);
            end
            FN_POP_FRONT, FN_POP_MIDDLE, FN_POP_BACK:
            begin
                if (shadow_entries.size() == 0)
                begin
                    r.pop_value = '1;
                    r.status = ST_EMPTY;
                end
                else if (fn == FN_POP_FRONT)
                    r.pop_value = shadow_entries.pop_front();
                else if (fn == FN_POP_MIDDLE)
                begin
                    idx = (shadow_entries.size() - 1) / 2;
                    r.pop_value = shadow_entries[idx];
                    shadow_entries.delete(idx);
                end
                else
                    r.pop_value = shadow_entries.pop_back();
            end
            default:
            begin
            end
        endcase
        r.fill_count = CW'(shadow_entries.size());
        return r;
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] v,
                             input logic typed, input queue_result_t typed_result);
        queue_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= fn;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_queue_op(fn, v);
        pending_results.push_back(typed ? typed_result : predicted);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: expected %h, got %h (result %0d)", what, want, got,
                     results_seen);
    endtask

    initial
    begin : receiver
        queue_result_t want;
        int            stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    note_mismatch("unexpected word", '0, m_tdata[VAL_W-1:0]);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.pop_value)
                        note_mismatch("pop_value", want.pop_value, m_tdata[VAL_W-1:0]);
                    if (m_tuser !== want.status)
                        note_mismatch("status", VAL_W'(want.status), VAL_W'(m_tuser));
                    if (m_tdata[VAL_W +: CW] !== want.fill_count)
                        note_mismatch("fill_count", VAL_W'(want.fill_count),
                                      VAL_W'(m_tdata[VAL_W +: CW]));
                end
                results_seen++;
                if (results_seen == HOLD_AFTER_RESULTS)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && rst_n && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int               sent;
        int               phase;
        int               phase_len;
        int               push_pct;
        logic [FUNC_W-1:0] fn;
        sent = 0;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++)
            send_word(DIR_ROWS[i].func, DIR_ROWS[i].value, DIR_ROWS[i].typed,
                      DIR_ROWS[i].result);

        // The first two walks fill the queue past full and then drain it past empty.
        while (sent < RANDOM_WORDS)
        begin
            if (phase == 0)
            begin
                push_pct = 100;
                phase_len = DEPTH + 8;
            end
            else if (phase == 1)
            begin
                push_pct = 0;
                phase_len = DEPTH + 8;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 90;
                    1: push_pct = 50;
                    default: push_pct = 10;
                endcase
                phase_len = $urandom_range(20, 120);
            end
            for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    fn = FUNC_W'($urandom_range(FN_UNUSED_6, FN_UNUSED_7));
                else if ($urandom_range(0, 99) < push_pct)
                    fn = FUNC_W'($urandom_range(FN_PUSH_FRONT, FN_PUSH_BACK));
                else
                    fn = FUNC_W'($urandom_range(FN_POP_FRONT, FN_POP_BACK));
                if (sent >= RANDOM_WORDS - QUIET_TAIL_WORDS)
                    quiet_tail = 1'b1;
                send_word(fn, pick_value(), 1'b0, '0);
                sent++;
            end
            phase++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch("missing word", '0, '0);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
sv/fmbq_pkg.sv
sv/fmbq_datapath.sv
sv/fmbq_ctrl.sv
sv/front_middle_back_queue_top.sv
tb/front_middle_back_queue_top_tb.sv
